[design/atss_pkg.sv]
`default_nettype none

package atss_pkg;

    // Default length of the longest signature that the history can hold.
    localparam int LONGEST_SIG_DEFAULT = 22;

    // Longest signature in the table and the width of one stored signature.
    localparam int SIG_MAX_LEN = 22;
    localparam int SIG_BITS    = 8 * SIG_MAX_LEN;
    localparam int SIG_COUNT   = 10;
    localparam int SIG_LEN_W   = 5;

    // What a signature reports when it is found.
    typedef enum logic [1:0] {
        KIND_LYRICS = 2'd0,
        KIND_ART    = 2'd1,
        KIND_TAIL   = 2'd2
    } sig_kind_t;

    // Key of the picture block in a comment header, 22 characters, written
    // as character codes with the first character in the high byte.
    localparam logic [8*22-1:0] SIG_PICTURE_KEY = {
        8'h4D, 8'h45, 8'h54, 8'h41, 8'h44, 8'h41, 8'h54, 8'h41, 8'h5F,
        8'h42, 8'h4C, 8'h4F, 8'h43, 8'h4B, 8'h5F,
        8'h50, 8'h49, 8'h43, 8'h54, 8'h55, 8'h52, 8'h45
    };

    // Signature text. Byte k of an entry is the character k places before
    // the last one, so byte 0 is compared with the newest word.
    localparam logic [0:SIG_COUNT-1][SIG_BITS-1:0] SIG_TEXT = '{
        SIG_BITS'("USLT"),
        SIG_BITS'("SYLT"),
        SIG_BITS'("APIC"),
        SIG_BITS'("LYRICS="),
        SIG_BITS'("UNSYNCEDLYRICS"),
        SIG_BITS'(SIG_PICTURE_KEY),
        SIG_BITS'("ftyp"),
        SIG_BITS'("DSD "),
        SIG_BITS'({8'hA9, "lyr"}),
        SIG_BITS'("covr")
    };

    localparam logic [0:SIG_COUNT-1][SIG_LEN_W-1:0] SIG_LEN = '{
        5'd4, 5'd4, 5'd4, 5'd7, 5'd14, 5'd22, 5'd4, 5'd4, 5'd4, 5'd4
    };

    localparam sig_kind_t [0:SIG_COUNT-1] SIG_KIND = '{
        KIND_LYRICS, KIND_LYRICS, KIND_ART, KIND_LYRICS, KIND_LYRICS,
        KIND_ART, KIND_TAIL, KIND_TAIL, KIND_LYRICS, KIND_ART
    };

    // Which window searches for each signature.
    localparam logic [0:SIG_COUNT-1] SIG_IN_HEAD = 10'b1111_1111_00;
    localparam logic [0:SIG_COUNT-1] SIG_IN_TAIL = 10'b1110_0000_11;

    // Window kinds as carried by the region field.
    localparam logic REGION_HEAD = 1'b0;
    localparam logic REGION_TAIL = 1'b1;

endpackage

`default_nettype wire

[design/audio_tag_signature_scanner_top.sv]
`default_nettype none

// Scans the bytes of a head window and then a tail window of an audio file for
// tag signatures (ID3 lyrics and picture frames, Vorbis comment keys, MP4 atoms,
// the MP4 and DSF file marks) and reports sticky lyrics, album-art and
// tail-scan-needed flags with one result word on the last byte of each window.
// One byte is taken every clock unless the input stalls: an accepted byte sits
// in the input register, the signature compare against the byte history runs
// while it is held and the flags land in the result register as it moves on,
// so a result passes the input register and then the result register. The
// input stalls only while a byte is held and the result register is full and
// stalled. A first byte clears the history; in a head window, the flags too.
module audio_tag_signature_scanner_top #(
    parameter int LONGEST_SIGNATURE = atss_pkg::LONGEST_SIG_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic region,
    input  wire logic first_in_region,
    input  wire logic last_in_region,

    output logic      out_valid,
    input  wire logic out_stall,
    output logic      has_lyrics,
    output logic      has_album_art,
    output logic      needs_tail_scan,
    output logic      window_kind
);

    localparam int HIST_DEPTH = LONGEST_SIGNATURE - 1;

    // Input register.
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_region_reg;
    logic       s1_first_reg;
    logic       s1_last_reg;

    // Scan state.
    logic [HIST_DEPTH-1:0][7:0] hist_reg, hist_next;
    logic lyrics_reg, lyrics_next;
    logic art_reg, art_next;
    logic tail_reg, tail_next;

    // Result register.
    logic out_valid_reg, out_valid_next;
    logic out_lyrics_reg;
    logic out_art_reg;
    logic out_tail_reg;
    logic out_kind_reg;

    logic advance;
    logic in_fire;
    logic s1_fire;

    logic [HIST_DEPTH-1:0][7:0]        hist_eff;
    logic [LONGEST_SIGNATURE-1:0][7:0] win;
    logic [atss_pkg::SIG_COUNT-1:0]    sig_match;
    logic lyrics_hit;
    logic art_hit;
    logic tail_hit;
    logic flags_clear;

    // Handshake: the held word moves on whenever the result register can take it.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;
    assign s1_fire  = s1_valid_reg && advance;

    // A first word sees a cleared history; the newest word leads the window.
    assign hist_eff = s1_first_reg ? '0 : hist_reg;
    assign win      = {hist_eff, s1_byte_reg};

    // One comparator row per signature, each byte checked against its place.
    for (genvar s = 0; s < atss_pkg::SIG_COUNT; s++) begin : g_sig
        localparam int Len = int'(atss_pkg::SIG_LEN[s]);
        logic [atss_pkg::SIG_MAX_LEN-1:0] eq;
        for (genvar k = 0; k < atss_pkg::SIG_MAX_LEN; k++) begin : g_byte
            if (k < Len && Len <= LONGEST_SIGNATURE) begin : g_cmp
                assign eq[k] = (win[k] == atss_pkg::SIG_TEXT[s][8*k +: 8]);
            end
            else begin : g_pad
                assign eq[k] = 1'b1;
            end
        end
        if (Len <= LONGEST_SIGNATURE) begin : g_fit
            assign sig_match[s] = (&eq) &&
                ((s1_region_reg == atss_pkg::REGION_TAIL) ?
                    atss_pkg::SIG_IN_TAIL[s] : atss_pkg::SIG_IN_HEAD[s]);
        end
        else begin : g_nofit
            assign sig_match[s] = 1'b0 & (&eq);
        end
    end

    // Sort the matches by what they report.
    always_comb
    begin
        lyrics_hit = 1'b0;
        art_hit    = 1'b0;
        tail_hit   = 1'b0;
        for (int s = 0; s < atss_pkg::SIG_COUNT; s++)
        begin
            case (atss_pkg::SIG_KIND[s])
                atss_pkg::KIND_LYRICS: lyrics_hit = lyrics_hit | sig_match[s];
                atss_pkg::KIND_ART:    art_hit    = art_hit | sig_match[s];
                atss_pkg::KIND_TAIL:   tail_hit   = tail_hit | sig_match[s];
                default:               tail_hit   = tail_hit;
            endcase
        end
    end

    // Next scan state and result.
    assign flags_clear = s1_first_reg && (s1_region_reg == atss_pkg::REGION_HEAD);

    always_comb
    begin
        hist_next      = hist_reg;
        lyrics_next    = lyrics_reg;
        art_next       = art_reg;
        tail_next      = tail_reg;
        out_valid_next = advance ? 1'b0 : out_valid_reg;
        if (s1_fire)
        begin
            hist_next      = {hist_eff[HIST_DEPTH-2:0], s1_byte_reg};
            lyrics_next    = (lyrics_reg && !flags_clear) || lyrics_hit;
            art_next       = (art_reg && !flags_clear) || art_hit;
            tail_next      = (tail_reg && !flags_clear) || tail_hit;
            out_valid_next = s1_last_reg;
        end
    end

    assign s1_valid_next = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
            lyrics_reg    <= 1'b0;
            art_reg       <= 1'b0;
            tail_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            hist_reg      <= hist_next;
            lyrics_reg    <= lyrics_next;
            art_reg       <= art_next;
            tail_reg      <= tail_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg   <= data_byte;
            s1_region_reg <= region;
            s1_first_reg  <= first_in_region;
            s1_last_reg   <= last_in_region;
        end
        if (s1_fire && s1_last_reg)
        begin
            out_lyrics_reg <= lyrics_next;
            out_art_reg    <= art_next;
            out_tail_reg   <= tail_next;
            out_kind_reg   <= s1_region_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign has_lyrics      = out_lyrics_reg;
    assign has_album_art   = out_art_reg;
    assign needs_tail_scan = out_tail_reg;
    assign window_kind     = out_kind_reg;

`ifndef SYNTHESIS
    // The input stalls only behind a held word.
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with no word held");

    // A last word yields a result of its own window kind.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> out_valid_reg && window_kind == $past(s1_region_reg))
        else $error("last word did not produce its result");

    // A head start leaves only the flags found on that word.
    a_head_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && flags_clear |=> lyrics_reg == $past(lyrics_hit)
            && art_reg == $past(art_hit) && tail_reg == $past(tail_hit))
        else $error("head start did not clear the flags");

    // The history moves only when a word is scanned.
    a_hist_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(hist_reg))
        else $error("history changed without a scanned word");
`endif

endmodule

`default_nettype wire
